// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: word types, operation and status codes,
// and parameter defaults.
// No dependencies.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 8;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry_id;
        logic [31:0] entry_priority;
    } t_spq_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [7:0]  head_id;
        logic [31:0] head_priority;
        logic [4:0]  occupancy;
    } t_spq_out;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } t_spq_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: a row of spq_cell slots kept in ascending priority order,
// with the command decode, count and output register. Depends on spq_pkg, spq_cell.
//
// Takes one word per clock while the output register is empty or being drained,
// and returns its result in the next cycle through that register. Every slot
// compares its priority and id with the incoming word in parallel, so the time
// for add, pop and remove does not depend on occupancy; the critical path is the
// per-slot 32-bit compare plus the match encoder over CAPACITY slots. No clearing
// pass is needed after reset.
`default_nettype none
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = spq_pkg::ID_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_spq_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_spq_out      o_out_data
);
    import spq_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = $clog2(CAPACITY);
    localparam int ID_EXT  = (ID_BITS > 8) ? ID_BITS : 8;
    localparam int CNT_EXT = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid;
    t_spq_out           r_out, n_out;
    logic               w_accept;
    t_spq_ctl           w_ctl;
    logic [POS_W-1:0]   w_del_pos, w_match_pos;
    logic [ID_EXT-1:0]  w_id_ext, w_head_ext;
    logic [ID_BITS-1:0] w_cmd_id;
    logic [CNT_EXT-1:0] w_occ_ext;
    logic               w_any_match;

    logic [ID_BITS-1:0] w_id    [CAPACITY];
    logic [31:0]        w_prio  [CAPACITY];
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_match;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_id_ext    = ID_EXT'(i_in_data.entry_id);
    assign w_cmd_id    = w_id_ext[ID_BITS-1:0];
    assign w_any_match = |w_match;

    // Ids held are unique, so at most one match bit is set.
    always_comb begin
        w_match_pos = '0;
        for (int b = 0; b < POS_W; b++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (((i >> b) & 1) == 1) begin
                    w_match_pos[b] = w_match_pos[b] | w_match[i];
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ID_BITS-1:0] w_lid, w_rid;
            logic [31:0]        w_lprio, w_rprio;
            logic               w_lle;
            if (g == 0) begin : g_first
                assign w_lid   = '0;
                assign w_lprio = '0;
                assign w_lle   = 1'b1;
            end else begin : g_mid
                assign w_lid   = w_id[g-1];
                assign w_lprio = w_prio[g-1];
                assign w_lle   = w_le[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_rid   = w_id[g];
                assign w_rprio = w_prio[g];
            end else begin : g_inner
                assign w_rid   = w_id[g+1];
                assign w_rprio = w_prio[g+1];
            end
            spq_cell #(
                .IDX     (g),
                .ID_BITS (ID_BITS),
                .CNT_W   (CNT_W),
                .POS_W   (POS_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_del_pos    (w_del_pos),
                .i_cmd_id     (w_cmd_id),
                .i_cmd_prio   (i_in_data.entry_priority),
                .i_left_id    (w_lid),
                .i_left_prio  (w_lprio),
                .i_left_le    (w_lle),
                .i_right_id   (w_rid),
                .i_right_prio (w_rprio),
                .o_id         (w_id[g]),
                .o_prio       (w_prio[g]),
                .o_le         (w_le[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    assign w_head_ext = ID_EXT'(w_id[0]);

    always_comb begin
        w_ctl      = '0;
        w_del_pos  = w_match_pos;
        n_count    = r_count;
        n_out      = '0;
        unique case (i_in_data.kind)
            KIND_ADD: begin
                if (w_any_match) begin
                    n_out.status = ST_DUPLICATE;
                end else if (r_count >= CNT_FULL) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + CNT_ONE;
                end
            end
            KIND_POP: begin
                w_del_pos = '0;
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    w_ctl.del           = w_accept;
                    n_count             = r_count - CNT_ONE;
                    n_out.head_valid    = 1'b1;
                    n_out.head_id       = w_head_ext[7:0];
                    n_out.head_priority = w_prio[0];
                end
            end
            KIND_REMOVE: begin
                if (w_any_match) begin
                    w_ctl.del = w_accept;
                    n_count   = r_count - CNT_ONE;
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        w_occ_ext       = CNT_EXT'(n_count);
        n_out.occupancy = w_occ_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("occupancy above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("occupancy changed without an accepted word");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.kind == KIND_POP && r_count != '0)
        |=> (o_out_valid && o_out_data.head_valid && o_out_data.status == ST_OK))
        else $error("pop of nonempty queue returned no head");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted queue: holds an id and a priority, shifts right on insert
// and left on delete. Depends on spq_pkg.
`default_nettype none
module spq_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = spq_pkg::ID_BITS_DEF,
    parameter int CNT_W   = 5,
    parameter int POS_W   = 4
) (
    input  wire logic                i_clk,
    input  wire spq_pkg::t_spq_ctl   i_ctl,
    input  wire logic [CNT_W-1:0]    i_count,
    input  wire logic [POS_W-1:0]    i_del_pos,
    input  wire logic [ID_BITS-1:0]  i_cmd_id,
    input  wire logic [31:0]         i_cmd_prio,
    input  wire logic [ID_BITS-1:0]  i_left_id,
    input  wire logic [31:0]         i_left_prio,
    input  wire logic                i_left_le,
    input  wire logic [ID_BITS-1:0]  i_right_id,
    input  wire logic [31:0]         i_right_prio,
    output logic [ID_BITS-1:0]       o_id,
    output logic [31:0]              o_prio,
    output logic                     o_le,
    output logic                     o_match
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
    localparam logic [POS_W-1:0] IDX_POS = POS_W'(IDX);

    logic [ID_BITS-1:0] r_id,   n_id;
    logic [31:0]        r_prio, n_prio;
    logic               w_valid;

    assign w_valid = IDX_CNT < i_count;
    // Sorted order makes the le flags a run of ones followed by zeros.
    assign o_le    = w_valid && (r_prio <= i_cmd_prio);
    assign o_match = w_valid && (r_id == i_cmd_id);
    assign o_id    = r_id;
    assign o_prio  = r_prio;

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        if (i_ctl.ins && !o_le) begin
            if (i_left_le) begin
                n_id   = i_cmd_id;
                n_prio = i_cmd_prio;
            end else begin
                n_id   = i_left_id;
                n_prio = i_left_prio;
            end
        end else if (i_ctl.del && (IDX_POS >= i_del_pos)) begin
            n_id   = i_right_id;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule
`default_nettype wire
